// ===== src/bblur_pkg.sv =====
// Shared constants, types and helper functions for the 3x3 box blur.
`default_nettype none

package bblur_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CH_W      = 8;
  localparam int NUM_LANES = 3;
  localparam int PIX_W     = CH_W * NUM_LANES;
  localparam int CFG_W     = 11;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // rows run two past the frame while draining
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 3);

  // 3x3 sum of 8-bit values plus rounding half, and the reciprocal format
  localparam int SUM_W   = CH_W + 4;
  localparam int RECIP_F = 16;
  localparam int RECIP_W = RECIP_F + 1;
  localparam int CNT_W   = 4;
  localparam int HALF_W  = 3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } nbr_mask_t;

  typedef struct packed {
    logic                 shift;
    logic                 ld_sum;
    logic                 ld_mean;
    nbr_mask_t            mask;
    logic [HALF_W-1:0]    half;
    logic [RECIP_W-1:0]   recip;
  } lane_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  // number of in-frame neighbors: (1+left+right) * (1+top+bottom)
  function automatic logic [CNT_W-1:0] nbr_count(input nbr_mask_t m);
    logic [1:0] nc;
    logic [1:0] nr;
    nc = 2'd1 + 2'(m.left) + 2'(m.right);
    nr = 2'd1 + 2'(m.top) + 2'(m.bottom);
    return CNT_W'(nc) * CNT_W'(nr);
  endfunction

  // ceil(2^16 / n); exact quotient for every numerator below 2^12
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] res;
    case (n)
      4'd1:    res = RECIP_W'(65536);
      4'd2:    res = RECIP_W'(32768);
      4'd3:    res = RECIP_W'(21846);
      4'd4:    res = RECIP_W'(16384);
      4'd5:    res = RECIP_W'(13108);
      4'd6:    res = RECIP_W'(10923);
      4'd7:    res = RECIP_W'(9363);
      4'd8:    res = RECIP_W'(8192);
      4'd9:    res = RECIP_W'(7282);
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/bblur_line_buf.sv =====
// Two line stores held as one memory entry per column, with same-cycle forwarding.
`default_nettype none

module bblur_line_buf (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [bblur_pkg::COL_W-1:0]   rd_addr,
  input  logic                          wr_en,
  input  logic [bblur_pkg::COL_W-1:0]   wr_addr,
  input  logic [bblur_pkg::PIX_W-1:0]   wr_up,
  input  logic [bblur_pkg::PIX_W-1:0]   wr_mid,
  output logic [bblur_pkg::PIX_W-1:0]   up_q,
  output logic [bblur_pkg::PIX_W-1:0]   mid_q
);
  import bblur_pkg::*;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_up, wr_mid};
    end
  end

  // one-pixel-wide frames read the column written in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        q_r <= {wr_up, wr_mid};
      end else begin
        q_r <= mem[rd_addr];
      end
    end
  end

  assign up_q  = q_r[2*PIX_W-1:PIX_W];
  assign mid_q = q_r[PIX_W-1:0];

endmodule

`default_nettype wire

// ===== src/bblur_lane.sv =====
// One color channel: 3x3 window, masked sum and reciprocal multiply.
`default_nettype none

module bblur_lane (
  input  logic                        clk,
  input  bblur_pkg::lane_ctl_t        ctl,
  input  logic [bblur_pkg::CH_W-1:0]  col_up,
  input  logic [bblur_pkg::CH_W-1:0]  col_mid,
  input  logic [bblur_pkg::CH_W-1:0]  col_low,
  output logic [bblur_pkg::CH_W-1:0]  mean
);
  import bblur_pkg::*;

  // win_r[col][row]: col 0 oldest, row 0 upper
  logic [CH_W-1:0]            win_r [3][3];
  logic [SUM_W-1:0]           sum_nxt;
  logic [SUM_W-1:0]           sum_r;
  logic [SUM_W+RECIP_W-1:0]   prod;
  logic [CH_W-1:0]            mean_r;
  logic [2:0]                 col_en;
  logic [2:0]                 row_en;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2][0] <= col_up;
      win_r[2][1] <= col_mid;
      win_r[2][2] <= col_low;
    end
  end

  always_comb begin
    col_en  = {ctl.mask.right, 1'b1, ctl.mask.left};
    row_en  = {ctl.mask.bottom, 1'b1, ctl.mask.top};
    sum_nxt = SUM_W'(ctl.half);
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (col_en[c] && row_en[r]) begin
          sum_nxt = sum_nxt + SUM_W'(win_r[c][r]);
        end
      end
    end
  end

  assign prod = (SUM_W+RECIP_W)'(sum_r) * (SUM_W+RECIP_W)'(ctl.recip);

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      sum_r <= sum_nxt;
    end
    if (ctl.ld_mean) begin
      mean_r <= prod[RECIP_F +: CH_W];
    end
  end

  assign mean = mean_r;

endmodule

`default_nettype wire

// ===== src/box_blur_3x3_edge_aware.sv =====
// Top level of the streaming 3x3 edge-aware box blur.
//
//   port group | dir | handshake          | payload
//   -----------+-----+--------------------+-------------------------------------------
//   in_*       | in  | in_valid/in_stall   | in_command, in_red_in/green_in/blue_in
//   out_*      | out | out_valid/out_stall | out_red_out/green_out/blue_out, frame_last
//   APB        | in  | psel/penable/pready | paddr, pwdata, prdata
//
// Up to one beat per cycle in and out while neither side stalls. A beat reaches the output
// register through these registered steps: line store read at the accepting edge, then window
// shift, masked sum, reciprocal multiply.
// The line store memory has one read and one write port, which sets the one-pixel rate.
// Reset clears the pipeline valids and frame position and sets width and height to 1024; line stores are not cleared.
// Each stage holds while the one after it is full and stalled.
`default_nettype none

module box_blur_3x3_edge_aware (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bblur_pkg::ADDR_W-1:0]    paddr,
  input  logic [bblur_pkg::DATA_W-1:0]    pwdata,
  output logic [bblur_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [bblur_pkg::CH_W-1:0]      in_red_in,
  input  logic [bblur_pkg::CH_W-1:0]      in_green_in,
  input  logic [bblur_pkg::CH_W-1:0]      in_blue_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bblur_pkg::CH_W-1:0]      out_red_out,
  output logic [bblur_pkg::CH_W-1:0]      out_green_out,
  output logic [bblur_pkg::CH_W-1:0]      out_blue_out,
  output logic                            out_frame_last
);
  import bblur_pkg::*;

  // configuration
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic               cfg_wr;

  // frame position of the next beat
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  logic [COL_W-1:0]   wm1;
  logic [ROW_W-1:0]   hgt;
  logic               frame_in;
  logic               in_fire;
  logic               take;
  logic               has_out;
  logic               is_last;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  nbr_mask_t          mask_nxt;

  // pipeline
  logic               s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic               s1_ok, s2_ok, s3_ok, s4_ok, s1_go;
  logic [PIX_W-1:0]   s1_px_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_has_out_r, s2_has_out_r;
  logic               s1_last_r, s2_last_r, s3_last_r, out_last_r;
  nbr_mask_t          s1_mask_r, s2_mask_r;
  logic [RECIP_W-1:0] s3_recip_r;
  logic [CNT_W-1:0]   s2_cnt;

  logic [PIX_W-1:0]   up_q, mid_q;
  lane_ctl_t          lane_ctl;
  logic [CH_W-1:0]    lane_mean [NUM_LANES];

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = DATA_W'(width_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(height_r);
      default:          prdata = '0;
    endcase
  end

  // handshake chain
  assign s4_ok    = !out_valid_r || !out_stall;
  assign s3_ok    = !s3_v_r || s4_ok;
  assign s2_ok    = !s2_v_r || s3_ok;
  assign s1_ok    = !s1_v_r || s2_ok;
  assign s1_go    = s1_v_r && s2_ok;
  assign in_stall = !s1_ok;
  assign in_fire  = in_valid && s1_ok;

  assign hgt      = ROW_W'(height_r);
  assign wm1      = COL_W'(width_r - DIM_W'(1));
  assign frame_in = row_r >= hgt;
  assign take     = in_fire && ((in_command == CMD_FLUSH) == frame_in);

  // position of the output this beat completes, its border mask, and the next frame position
  always_comb begin
    has_out = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
    if (col_r != '0) begin
      out_row = row_r - ROW_W'(1);
      out_col = col_r - COL_W'(1);
    end else begin
      out_row = row_r - ROW_W'(2);
      out_col = wm1;
    end
    mask_nxt.left   = out_col != '0;
    mask_nxt.right  = ((COL_W+1)'(out_col) + (COL_W+1)'(1)) < (COL_W+1)'(width_r);
    mask_nxt.top    = out_row != '0;
    mask_nxt.bottom = (out_row + ROW_W'(1)) < hgt;
    is_last = has_out && (out_row == hgt - ROW_W'(1)) && (out_col == wm1);

    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      if (is_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (((COL_W+1)'(col_r) + (COL_W+1)'(1)) >= (COL_W+1)'(width_r)) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= clamp_dim(CFG_W'(1024), MAX_WIDTH);
      height_r    <= clamp_dim(CFG_W'(1024), MAX_HEIGHT);
      col_r       <= '0;
      row_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_FRAME_WIDTH:  width_r  <= clamp_dim(pwdata[CFG_W-1:0], MAX_WIDTH);
          REG_FRAME_HEIGHT: height_r <= clamp_dim(pwdata[CFG_W-1:0], MAX_HEIGHT);
          default:          ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (s1_ok) s1_v_r <= take;
      if (s2_ok) s2_v_r <= s1_v_r;
      if (s3_ok) s3_v_r <= s2_v_r && s2_has_out_r;
      if (s4_ok) out_valid_r <= s3_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (s1_ok) begin
      s1_px_r      <= (in_command == CMD_FLUSH) ? '0 : {in_red_in, in_green_in, in_blue_in};
      s1_col_r     <= col_r;
      s1_has_out_r <= has_out;
      s1_last_r    <= is_last;
      s1_mask_r    <= mask_nxt;
    end
    if (s2_ok) begin
      s2_has_out_r <= s1_has_out_r;
      s2_last_r    <= s1_last_r;
      s2_mask_r    <= s1_mask_r;
    end
    if (s3_ok) begin
      s3_last_r  <= s2_last_r;
      s3_recip_r <= recip_of(s2_cnt);
    end
    if (s4_ok) begin
      out_last_r <= s3_last_r;
    end
  end

  assign s2_cnt = nbr_count(s2_mask_r);

  bblur_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (col_r),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_up   (mid_q),
    .wr_mid  (s1_px_r),
    .up_q    (up_q),
    .mid_q   (mid_q)
  );

  always_comb begin
    lane_ctl.shift   = s1_go;
    lane_ctl.ld_sum  = s3_ok && s2_v_r;
    lane_ctl.ld_mean = s4_ok && s3_v_r;
    lane_ctl.mask    = s2_mask_r;
    lane_ctl.half    = HALF_W'(s2_cnt >> 1);
    lane_ctl.recip   = s3_recip_r;
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    bblur_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .col_up  (up_q[CH_W*i +: CH_W]),
      .col_mid (mid_q[CH_W*i +: CH_W]),
      .col_low (s1_px_r[CH_W*i +: CH_W]),
      .mean    (lane_mean[i])
    );
  end

  // merge: lanes are packed blue in lane 0, red in lane 2
  assign out_valid      = out_valid_r;
  assign out_red_out    = lane_mean[2];
  assign out_green_out  = lane_mean[1];
  assign out_blue_out   = lane_mean[0];
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire
